@@ src/csba_pkg.sv @@
// ----------------------------------------------------------------------------
// csba_pkg
// Shared types and constants for the clipped, scaled blit address generator.
// ----------------------------------------------------------------------------
package csba_pkg;

  localparam int SCALE_DEF  = 2;
  localparam int VIEW_W_DEF = 640;
  localparam int VIEW_H_DEF = 400;

  // coordinate width covers views up to 2048, phase width covers scales up to 4
  localparam int CRD_W   = 12;
  localparam int OFF_W   = 12;
  localparam int PH_W    = 2;
  localparam int SPR_W   = 10;
  localparam int DEST_W  = 18;
  localparam int SRC_W   = 20;
  localparam int COORD_W = 16;

  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 2'd3;

  localparam logic [COORD_W-1:0] CLIP_LEFT_RST   = 16'd0;
  localparam logic [COORD_W-1:0] CLIP_RIGHT_RST  = 16'd640;
  localparam logic [COORD_W-1:0] CLIP_TOP_RST    = 16'd0;
  localparam logic [COORD_W-1:0] CLIP_BOTTOM_RST = 16'd400;

  typedef struct packed {
    logic              op;
    logic              visible;
    logic [CRD_W-1:0]  col_start;
    logic [CRD_W-1:0]  col_end;
    logic [CRD_W-1:0]  row_start;
    logic [CRD_W-1:0]  row_end;
    logic [PH_W-1:0]   col_ph;
    logic [PH_W-1:0]   row_ph;
    logic [SPR_W-1:0]  scol;
    logic [SRC_W-1:0]  row_base;
    logic [DEST_W-1:0] dest_base;
    logic [SPR_W-1:0]  width;
  } job_t;

endpackage

@@ src/csba_front.sv @@
// ----------------------------------------------------------------------------
// csba_front
// Accepts items, holds the clip registers and turns a start into clipped
// geometry with initial source and destination bases over three stages.
// ----------------------------------------------------------------------------
module csba_front #(
  parameter int SCALE  = csba_pkg::SCALE_DEF,
  parameter int VIEW_W = csba_pkg::VIEW_W_DEF,
  parameter int VIEW_H = csba_pkg::VIEW_H_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [csba_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [csba_pkg::COORD_W-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                in_op_i,
  input  logic [csba_pkg::COORD_W-1:0]        in_x_i,
  input  logic [csba_pkg::COORD_W-1:0]        in_y_i,
  input  logic [csba_pkg::SPR_W-1:0]          in_w_i,
  input  logic [csba_pkg::SPR_W-1:0]          in_h_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output csba_pkg::job_t                      job_o
);

  localparam int CW = csba_pkg::COORD_W;
  localparam int RW = csba_pkg::CRD_W;
  localparam int OW = csba_pkg::OFF_W;
  localparam int DIV_K = 16;
  localparam int DIV_M = (2**DIV_K + SCALE - 1) / SCALE;
  localparam int PROD_W = OW + DIV_K + 1;
  localparam logic [CW-1:0] VIEW_W_L = CW'(VIEW_W);
  localparam logic [CW-1:0] VIEW_H_L = CW'(VIEW_H);
  localparam logic [CW-1:0] SCALE_L  = CW'(SCALE);
  localparam logic [DIV_K:0] DIV_M_L = (DIV_K+1)'(DIV_M);

  logic [CW-1:0] clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= csba_pkg::CLIP_LEFT_RST;
      clip_right_q  <= csba_pkg::CLIP_RIGHT_RST;
      clip_top_q    <= csba_pkg::CLIP_TOP_RST;
      clip_bottom_q <= csba_pkg::CLIP_BOTTOM_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        csba_pkg::CFG_CLIP_LEFT:   clip_left_q   <= cfg_data_i;
        csba_pkg::CFG_CLIP_RIGHT:  clip_right_q  <= cfg_data_i;
        csba_pkg::CFG_CLIP_TOP:    clip_top_q    <= cfg_data_i;
        csba_pkg::CFG_CLIP_BOTTOM: clip_bottom_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || job_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o  = en1;
  assign job_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1: scale, clamp and intersect
  logic [CW-1:0] x_w, y_w, ex_w, ey_w, cl_w, cr_w, ct_w, cb_w;
  logic [CW-1:0] sx0_w, sx1_w, sy0_w, sy1_w, col_off_w, row_off_w;
  logic          vis_w;

  always_comb begin
    x_w  = CW'(in_x_i * SCALE_L);
    y_w  = CW'(in_y_i * SCALE_L);
    ex_w = x_w + CW'({6'd0, in_w_i} * SCALE_L);
    ey_w = y_w + CW'({6'd0, in_h_i} * SCALE_L);
    cl_w = clip_left_q[CW-1]  ? '0 : clip_left_q;
    ct_w = clip_top_q[CW-1]   ? '0 : clip_top_q;
    cr_w = ($signed(clip_right_q) > $signed(VIEW_W_L)) ? VIEW_W_L : clip_right_q;
    cb_w = ($signed(clip_bottom_q) > $signed(VIEW_H_L)) ? VIEW_H_L : clip_bottom_q;
    sx0_w = ($signed(x_w) > $signed(cl_w)) ? x_w : cl_w;
    sy0_w = ($signed(y_w) > $signed(ct_w)) ? y_w : ct_w;
    sx1_w = ($signed(ex_w) < $signed(cr_w)) ? ex_w : cr_w;
    sy1_w = ($signed(ey_w) < $signed(cb_w)) ? ey_w : cb_w;
    vis_w = (in_w_i != '0) && (in_h_i != '0) &&
            ($signed(sx0_w) < $signed(sx1_w)) && ($signed(sy0_w) < $signed(sy1_w));
    col_off_w = sx0_w - x_w;
    row_off_w = sy0_w - y_w;
  end

  logic              s1_op_q, s1_vis_q;
  logic [RW-1:0]     s1_sx0_q, s1_sx1_q, s1_sy0_q, s1_sy1_q;
  logic [OW-1:0]     s1_coff_q, s1_roff_q;
  logic [csba_pkg::SPR_W-1:0] s1_w_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_op_q   <= in_op_i;
      s1_vis_q  <= vis_w;
      s1_sx0_q  <= sx0_w[RW-1:0];
      s1_sx1_q  <= sx1_w[RW-1:0];
      s1_sy0_q  <= sy0_w[RW-1:0];
      s1_sy1_q  <= sy1_w[RW-1:0];
      s1_coff_q <= col_off_w[OW-1:0];
      s1_roff_q <= row_off_w[OW-1:0];
      s1_w_q    <= in_w_i;
    end
  end

  // stage 2: reciprocal multiply for the source offsets, destination row base
  logic [PROD_W-1:0] cprod_w, rprod_w;
  logic [2*RW-1:0]   dprod_w;

  assign cprod_w = PROD_W'(s1_coff_q) * PROD_W'(DIV_M_L);
  assign rprod_w = PROD_W'(s1_roff_q) * PROD_W'(DIV_M_L);
  assign dprod_w = (2*RW)'(s1_sy0_q) * (2*RW)'(VIEW_W_L);

  logic              s2_op_q, s2_vis_q;
  logic [RW-1:0]     s2_sx0_q, s2_sx1_q, s2_sy0_q, s2_sy1_q;
  logic [OW-1:0]     s2_coff_q, s2_roff_q, s2_cq_q, s2_rq_q;
  logic [csba_pkg::DEST_W-1:0] s2_dbase_q;
  logic [csba_pkg::SPR_W-1:0]  s2_w_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_op_q    <= s1_op_q;
      s2_vis_q   <= s1_vis_q;
      s2_sx0_q   <= s1_sx0_q;
      s2_sx1_q   <= s1_sx1_q;
      s2_sy0_q   <= s1_sy0_q;
      s2_sy1_q   <= s1_sy1_q;
      s2_coff_q  <= s1_coff_q;
      s2_roff_q  <= s1_roff_q;
      s2_cq_q    <= cprod_w[DIV_K +: OW];
      s2_rq_q    <= rprod_w[DIV_K +: OW];
      s2_dbase_q <= dprod_w[csba_pkg::DEST_W-1:0];
      s2_w_q     <= s1_w_q;
    end
  end

  // stage 3: remainders give the scale phases, source row base
  logic [OW-1:0] crem_w, rrem_w;
  csba_pkg::job_t job_d, job_q;

  always_comb begin
    crem_w = s2_coff_q - OW'(s2_cq_q * OW'(SCALE));
    rrem_w = s2_roff_q - OW'(s2_rq_q * OW'(SCALE));
    job_d.op        = s2_op_q;
    job_d.visible   = s2_vis_q;
    job_d.col_start = s2_sx0_q;
    job_d.col_end   = s2_sx1_q;
    job_d.row_start = s2_sy0_q;
    job_d.row_end   = s2_sy1_q;
    job_d.col_ph    = crem_w[csba_pkg::PH_W-1:0];
    job_d.row_ph    = rrem_w[csba_pkg::PH_W-1:0];
    job_d.scol      = s2_cq_q[csba_pkg::SPR_W-1:0];
    job_d.row_base  = csba_pkg::SRC_W'(s2_rq_q[csba_pkg::SPR_W-1:0]) *
                      csba_pkg::SRC_W'(s2_w_q);
    job_d.dest_base = s2_dbase_q;
    job_d.width     = s2_w_q;
  end

  always_ff @(posedge clk_i) begin
    if (en3) job_q <= job_d;
  end

  assign job_o = job_q;

endmodule

@@ src/csba_queue.sv @@
// ----------------------------------------------------------------------------
// csba_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module csba_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  csba_pkg::job_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output csba_pkg::job_t rd_data_o
);

  localparam int DEPTH = csba_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  csba_pkg::job_t    mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              push, pop;

  assign wr_ready_o = count_q != CNT_W'(DEPTH);
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

@@ src/csba_back.sv @@
// ----------------------------------------------------------------------------
// csba_back
// Walks the clipped rectangle one pixel per transaction and registers results.
// ----------------------------------------------------------------------------
module csba_back #(
  parameter int SCALE  = csba_pkg::SCALE_DEF,
  parameter int VIEW_W = csba_pkg::VIEW_W_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  output logic                           job_ready_o,
  input  csba_pkg::job_t                 job_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_visible_o,
  output logic                           out_pixel_valid_o,
  output logic [csba_pkg::DEST_W-1:0]    out_dest_o,
  output logic [csba_pkg::SRC_W-1:0]     out_src_o,
  output logic                           out_last_o
);

  localparam int RW = csba_pkg::CRD_W;
  localparam int PW = csba_pkg::PH_W;
  localparam int DW = csba_pkg::DEST_W;
  localparam int SW = csba_pkg::SRC_W;
  localparam int WW = csba_pkg::SPR_W;
  localparam logic [PW-1:0] PH_MAX   = PW'(SCALE - 1);
  localparam logic [DW-1:0] VIEW_W_L = DW'(VIEW_W);

  logic          active_q, active_d;
  logic [RW-1:0] cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [RW-1:0] col_start_q, col_start_d, col_end_q, col_end_d, row_end_q, row_end_d;
  logic [PW-1:0] col_ph_q, col_ph_d, col_ph_start_q, col_ph_start_d, row_ph_q, row_ph_d;
  logic [WW-1:0] scol_q, scol_d, scol_start_q, scol_start_d, width_q, width_d;
  logic [SW-1:0] row_base_q, row_base_d;
  logic [DW-1:0] dest_base_q, dest_base_d;

  logic          ov_q, vis_q, vis_d, pv_q, pv_d, last_q, last_d;
  logic [DW-1:0] dest_q, dest_d;
  logic [SW-1:0] src_q, src_d;

  logic take, col_wrap, row_wrap;

  assign job_ready_o = !ov_q || out_ready_i;
  assign take = job_valid_i && job_ready_o;
  assign col_wrap = ({1'b0, cur_col_q} + 1'b1) >= {1'b0, col_end_q};
  assign row_wrap = ({1'b0, cur_row_q} + 1'b1) >= {1'b0, row_end_q};

  always_comb begin
    active_d       = active_q;
    cur_col_d      = cur_col_q;
    cur_row_d      = cur_row_q;
    col_start_d    = col_start_q;
    col_end_d      = col_end_q;
    row_end_d      = row_end_q;
    col_ph_d       = col_ph_q;
    col_ph_start_d = col_ph_start_q;
    row_ph_d       = row_ph_q;
    scol_d         = scol_q;
    scol_start_d   = scol_start_q;
    width_d        = width_q;
    row_base_d     = row_base_q;
    dest_base_d    = dest_base_q;
    vis_d  = 1'b0;
    pv_d   = 1'b0;
    last_d = 1'b0;
    dest_d = '0;
    src_d  = '0;
    if (job_i.op == csba_pkg::OP_START) begin
      vis_d          = job_i.visible;
      active_d       = job_i.visible;
      cur_col_d      = job_i.col_start;
      cur_row_d      = job_i.row_start;
      col_start_d    = job_i.col_start;
      col_end_d      = job_i.col_end;
      row_end_d      = job_i.row_end;
      col_ph_d       = job_i.col_ph;
      col_ph_start_d = job_i.col_ph;
      row_ph_d       = job_i.row_ph;
      scol_d         = job_i.scol;
      scol_start_d   = job_i.scol;
      width_d        = job_i.width;
      row_base_d     = job_i.row_base;
      dest_base_d    = job_i.dest_base;
    end else if (active_q) begin
      pv_d   = 1'b1;
      dest_d = dest_base_q + DW'(cur_col_q);
      src_d  = row_base_q + SW'(scol_q);
      last_d = col_wrap && row_wrap;
      if (col_wrap && row_wrap) begin
        active_d = 1'b0;
      end else if (col_wrap) begin
        cur_col_d   = col_start_q;
        scol_d      = scol_start_q;
        col_ph_d    = col_ph_start_q;
        cur_row_d   = cur_row_q + 1'b1;
        dest_base_d = dest_base_q + VIEW_W_L;
        if (row_ph_q == PH_MAX) begin
          row_ph_d   = '0;
          row_base_d = row_base_q + SW'(width_q);
        end else begin
          row_ph_d = row_ph_q + 1'b1;
        end
      end else begin
        cur_col_d = cur_col_q + 1'b1;
        if (col_ph_q == PH_MAX) begin
          col_ph_d = '0;
          scol_d   = scol_q + 1'b1;
        end else begin
          col_ph_d = col_ph_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (take) active_q <= active_d;
      if (job_ready_o) ov_q <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_col_q      <= cur_col_d;
      cur_row_q      <= cur_row_d;
      col_start_q    <= col_start_d;
      col_end_q      <= col_end_d;
      row_end_q      <= row_end_d;
      col_ph_q       <= col_ph_d;
      col_ph_start_q <= col_ph_start_d;
      row_ph_q       <= row_ph_d;
      scol_q         <= scol_d;
      scol_start_q   <= scol_start_d;
      width_q        <= width_d;
      row_base_q     <= row_base_d;
      dest_base_q    <= dest_base_d;
      vis_q          <= vis_d;
      pv_q           <= pv_d;
      last_q         <= last_d;
      dest_q         <= dest_d;
      src_q          <= src_d;
    end
  end

  assign out_valid_o       = ov_q;
  assign out_visible_o     = vis_q;
  assign out_pixel_valid_o = pv_q;
  assign out_dest_o        = dest_q;
  assign out_src_o         = src_q;
  assign out_last_o        = last_q;

endmodule

@@ src/clipped_scaled_blit_addresser.sv @@
// ----------------------------------------------------------------------------
// clipped_scaled_blit_addresser
// Address generator for a clipped sprite blit with integer upscaling.
// ----------------------------------------------------------------------------
// Usage:
//   Write the clip window on the cfg channel while no blit is in flight.
//   Send a start transaction (tuser 0) with position and size; its result
//   carries visible in tuser bit 0. Each step transaction (tuser 1) returns
//   one destination address and source offset with tuser bit 1 set, tlast
//   marking the final pixel; steps beyond the rectangle return all zeros.
//   A start while a blit runs abandons it.
// Timing:
//   One transaction per cycle sustained while m_axis_tready stays high. A
//   result passes through three front stages for geometry (reciprocal and
//   row base multiplies), the queue, then the output register of the pixel
//   walker. The walker updates its counters for one pixel per step it takes.
// Reset:
//   Clip window returns to 0..640 by 0..400, no blit active, queue empty.
// Stalls:
//   A stalled m_axis holds its result; the queue and front stages keep
//   accepting until full, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module clipped_scaled_blit_addresser #(
  parameter int SCALE  = csba_pkg::SCALE_DEF,
  parameter int VIEW_W = csba_pkg::VIEW_W_DEF,
  parameter int VIEW_H = csba_pkg::VIEW_H_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [csba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [csba_pkg::COORD_W-1:0]   cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // x_pos[15:0], y_pos[31:16], shape_width[41:32], shape_height[51:42]
  input  logic [55:0]                    s_axis_tdata,
  // operation[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // dest_address[17:0], source_offset[37:18]
  output logic [39:0]                    m_axis_tdata,
  // visible[0], pixel_valid[1]
  output logic [1:0]                     m_axis_tuser,
  output logic                           m_axis_tlast
);

  logic           f_valid, f_ready, q_valid, q_ready;
  csba_pkg::job_t f_job, q_job;
  logic           o_vis, o_pv;
  logic [csba_pkg::DEST_W-1:0] o_dest;
  logic [csba_pkg::SRC_W-1:0]  o_src;

  assign cfg_ready_o = 1'b1;

  csba_front #(
    .SCALE  (SCALE),
    .VIEW_W (VIEW_W),
    .VIEW_H (VIEW_H)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_x_i      (s_axis_tdata[15:0]),
    .in_y_i      (s_axis_tdata[31:16]),
    .in_w_i      (s_axis_tdata[41:32]),
    .in_h_i      (s_axis_tdata[51:42]),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  csba_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_job),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_job)
  );

  csba_back #(
    .SCALE  (SCALE),
    .VIEW_W (VIEW_W)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (q_valid),
    .job_ready_o       (q_ready),
    .job_i             (q_job),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_visible_o     (o_vis),
    .out_pixel_valid_o (o_pv),
    .out_dest_o        (o_dest),
    .out_src_o         (o_src),
    .out_last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, o_src, o_dest};
  assign m_axis_tuser = {o_pv, o_vis};

endmodule

@@ tb/sv/clipped_scaled_blit_addresser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_scaled_blit_addresser_tb
// Self-checking bench for the clipped, scaled blit address generator.
// Each start and step transaction on the input stream is predicted when it is
// accepted and compared field by field with the next output transaction.
// A short directed part covers the geometry extremes and the corner cases.
// It is followed by a series of clip window settings, each running blits with
// random content, broken blits and noise. Both stream sides idle at random,
// and one long receiver hold-off backs the block up until its input stalls.
// ----------------------------------------------------------------------------
module clipped_scaled_blit_addresser_tb;

  localparam int LIMIT     = 600000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE    = 20;

  localparam int DEST_W    = csba_pkg::DEST_W;
  localparam int SRC_W     = csba_pkg::SRC_W;
  localparam int COORD_W   = csba_pkg::COORD_W;
  localparam int CFG_IDX_W = csba_pkg::CFG_IDX_W;
  localparam int SCALE     = csba_pkg::SCALE_DEF;
  localparam int VIEW_W    = csba_pkg::VIEW_W_DEF;
  localparam int VIEW_H    = csba_pkg::VIEW_H_DEF;

  typedef struct packed {
    logic              visible;
    logic              pixel_valid;
    logic [DEST_W-1:0] dest;
    logic [SRC_W-1:0]  src;
    logic              last;
  } blit_result_t;

  class blit_scoreboard;
    logic [COORD_W-1:0] clip_reg [4];
    bit                 blit_busy;
    int                 row_now, col_now, org_x, org_y, spr_w;
    int                 first_col, stop_col, stop_row;
    blit_result_t       addr_due [$];
    int                 errors, starts, shown, pixels, lasts, idle_steps;

    function new();
      clip_reg[csba_pkg::CFG_CLIP_LEFT]   = csba_pkg::CLIP_LEFT_RST;
      clip_reg[csba_pkg::CFG_CLIP_RIGHT]  = csba_pkg::CLIP_RIGHT_RST;
      clip_reg[csba_pkg::CFG_CLIP_TOP]    = csba_pkg::CLIP_TOP_RST;
      clip_reg[csba_pkg::CFG_CLIP_BOTTOM] = csba_pkg::CLIP_BOTTOM_RST;
      blit_busy = 1'b0;
    endfunction

    function int wrap16(int v);
      logic signed [15:0] s;
      s = v[15:0];
      return int'(s);
    endfunction

    function void window(output int cl, output int cr, output int ct, output int cb);
      cl = wrap16(clip_reg[csba_pkg::CFG_CLIP_LEFT]);
      cr = wrap16(clip_reg[csba_pkg::CFG_CLIP_RIGHT]);
      ct = wrap16(clip_reg[csba_pkg::CFG_CLIP_TOP]);
      cb = wrap16(clip_reg[csba_pkg::CFG_CLIP_BOTTOM]);
      if (cl < 0) cl = 0;
      if (ct < 0) ct = 0;
      if (cr > VIEW_W) cr = VIEW_W;
      if (cb > VIEW_H) cb = VIEW_H;
    endfunction

    function bit clip_rect(input logic [15:0] xp, input logic [15:0] yp,
                           input logic [9:0] w, input logic [9:0] h,
                           output int x0, output int y0, output int x1, output int y1,
                           output int ox, output int oy);
      int cl, cr, ct, cb, ex, ey;
      window(cl, cr, ct, cb);
      ox = wrap16(wrap16(xp) * SCALE);
      oy = wrap16(wrap16(yp) * SCALE);
      ex = wrap16(ox + int'(w) * SCALE);
      ey = wrap16(oy + int'(h) * SCALE);
      x0 = ox > cl ? ox : cl;
      y0 = oy > ct ? oy : ct;
      x1 = ex < cr ? ex : cr;
      y1 = ey < cb ? ey : cb;
      if (w == 0 || h == 0) return 1'b0;
      return (x0 < x1) && (y0 < y1);
    endfunction

    function void note_register(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      clip_reg[idx] = val;
    endfunction

    function void note_request(logic op, logic [55:0] data);
      blit_result_t res;
      int x0, y0, x1, y1, ox, oy, srow, scol;
      res = '0;
      if (op == csba_pkg::OP_START) begin
        starts++;
        blit_busy = 1'b0;
        if (clip_rect(data[15:0], data[31:16], data[41:32], data[51:42],
                      x0, y0, x1, y1, ox, oy)) begin
          blit_busy = 1'b1;
          org_x     = ox;
          org_y     = oy;
          spr_w     = int'(data[41:32]);
          first_col = x0;
          stop_col  = x1;
          stop_row  = y1;
          row_now   = y0;
          col_now   = x0;
          res.visible = 1'b1;
          shown++;
        end
      end else if (blit_busy) begin
        srow = (row_now - org_y) / SCALE;
        scol = (col_now - org_x) / SCALE;
        res.pixel_valid = 1'b1;
        res.dest = DEST_W'(row_now * VIEW_W + col_now);
        res.src  = SRC_W'(srow * spr_w + scol);
        res.last = (col_now + 1 >= stop_col) && (row_now + 1 >= stop_row);
        pixels++;
        if (res.last) begin
          blit_busy = 1'b0;
          lasts++;
        end else if (col_now + 1 >= stop_col) begin
          col_now = first_col;
          row_now++;
        end else begin
          col_now++;
        end
      end else begin
        idle_steps++;
      end
      addr_due.push_back(res);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_response(logic [1:0] user, logic [39:0] data, logic last);
      blit_result_t want;
      if (addr_due.size() == 0) begin
        $error("output transaction with nothing expected: tuser 0x%0h tdata 0x%0h",
               user, data);
        errors++;
        return;
      end
      want = addr_due.pop_front();
      compare("visible", want.visible, user[0]);
      compare("pixel_valid", want.pixel_valid, user[1]);
      compare("dest_address", want.dest, data[17:0]);
      compare("source_offset", want.src, data[37:18]);
      compare("last_pixel", want.last, last);
    endfunction

    function int pending();
      return addr_due.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [COORD_W-1:0]   cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [55:0]          s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [39:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  blit_scoreboard sb = new();
  int             sent;
  int             windows;
  int             cycle_count = 0;
  bit             burst;
  int             backlog_req;

  clipped_scaled_blit_addresser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.note_register(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_response(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic [55:0] pack_start(logic [15:0] x, logic [15:0] y,
                                             logic [9:0] w, logic [9:0] h);
    return {4'b0, h, w, y, x};
  endfunction

  function automatic logic [55:0] rand_bits();
    logic [63:0] r64;
    r64 = {$urandom(), $urandom()};
    return {4'b0, r64[51:0]};
  endfunction

  // receiver: ready stretches broken by stalls, one long hold-off on request
  initial begin
    int gap;
    int served;
    served = 0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? 150 : $urandom_range(1, 12)) @(posedge clk_i);
      if (backlog_req != served) begin
        served = backlog_req;
        gap = LONG_HOLD;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(input logic op, input logic [55:0] data);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic write_window(input logic [15:0] l, input logic [15:0] r,
                              input logic [15:0] t, input logic [15:0] b);
    write_reg(csba_pkg::CFG_CLIP_LEFT, l);
    write_reg(csba_pkg::CFG_CLIP_RIGHT, r);
    write_reg(csba_pkg::CFG_CLIP_TOP, t);
    write_reg(csba_pkg::CFG_CLIP_BOTTOM, b);
    cfg_valid_i <= 1'b0;
    windows++;
  endtask

  // well-formed blit near the window, finished, overrun or abandoned part way
  task automatic send_blit();
    int cl, cr, ct, cb, w, h, xp, yp, x0, y0, x1, y1, ox, oy, npix, nstep, r;
    bit seen;
    r = $urandom_range(0, 99);
    w = r < 85 ? $urandom_range(1, 4) : (r < 97 ? $urandom_range(5, 12) : $urandom_range(13, 40));
    r = $urandom_range(0, 99);
    h = r < 85 ? $urandom_range(1, 4) : (r < 97 ? $urandom_range(5, 12) : $urandom_range(13, 40));
    sb.window(cl, cr, ct, cb);
    xp = cl / 2 - w + $urandom_range(0, (cr > cl ? (cr - cl) / 2 : 1) + w);
    yp = ct / 2 - h + $urandom_range(0, (cb > ct ? (cb - ct) / 2 : 1) + h);
    seen = sb.clip_rect(16'(xp), 16'(yp), 10'(w), 10'(h), x0, y0, x1, y1, ox, oy);
    npix = seen ? (x1 - x0) * (y1 - y0) : 0;
    if (npix > 0 && ($urandom_range(0, 99) < 15 || npix > 400))
      nstep = $urandom_range(0, npix > 60 ? 60 : npix - 1);
    else
      nstep = npix + ($urandom_range(0, 99) < 30 ? $urandom_range(1, 2) : 0);
    send_item(csba_pkg::OP_START, pack_start(16'(xp), 16'(yp), 10'(w), 10'(h)));
    repeat (nstep) send_item(csba_pkg::OP_STEP, rand_bits());
  endtask

  task automatic run_phase(input logic [15:0] l, input logic [15:0] r,
                           input logic [15:0] t, input logic [15:0] b,
                           input int quota, input bit press);
    int goal, pick;
    drain();
    write_window(l, r, t, b);
    goal = sent + quota;
    if (press) begin
      backlog_req++;
      burst = 1'b1;
      while (sent < goal - quota / 2) send_blit();
      burst = 1'b0;
    end
    while (sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_blit();
      end else if (pick < 88) begin
        send_item(csba_pkg::OP_START, rand_bits());
        repeat ($urandom_range(0, 3)) send_item(csba_pkg::OP_STEP, rand_bits());
      end else begin
        repeat ($urandom_range(1, 3)) send_item(csba_pkg::OP_STEP, rand_bits());
      end
    end
  endtask

  task automatic run_directed();
    send_item(csba_pkg::OP_STEP, rand_bits());
    send_item(csba_pkg::OP_START, pack_start(16'd0, 16'd0, 10'd0, 10'd5));
    send_item(csba_pkg::OP_START, pack_start(16'd0, 16'd0, 10'd5, 10'd0));
    send_item(csba_pkg::OP_START, pack_start(16'h8000, 16'h8000, 10'd1023, 10'd1023));
    repeat (3) send_item(csba_pkg::OP_STEP, 56'd0);
    // abandon the full-screen blit for one ending on the last view pixel
    send_item(csba_pkg::OP_START, pack_start(16'd319, 16'd199, 10'd1, 10'd1));
    repeat (5) send_item(csba_pkg::OP_STEP, {4'b0, {52{1'b1}}});
    send_item(csba_pkg::OP_START, pack_start(16'h7FFF, 16'h7FFF, 10'd1023, 10'd1023));
    repeat (2) send_item(csba_pkg::OP_STEP, rand_bits());
    // right edge wraps past the top of the 16-bit range
    send_item(csba_pkg::OP_START, pack_start(16'd16383, 16'd0, 10'd1023, 10'd1));
    send_item(csba_pkg::OP_STEP, rand_bits());
    send_item(csba_pkg::OP_START, pack_start(16'hFFFF, 16'hFFFF, 10'd1, 10'd1));
    send_item(csba_pkg::OP_START, pack_start(16'hFFFF, 16'hFFFF, 10'd2, 10'd2));
    repeat (5) send_item(csba_pkg::OP_STEP, rand_bits());
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= csba_pkg::CFG_CLIP_LEFT;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= csba_pkg::OP_START;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_phase(16'd0, 16'd640, 16'd0, 16'd400, 250, 1'b1);
    run_phase(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 200, 1'b0);
    run_phase(16'd500, 16'd100, 16'd0, 16'd400, 60, 1'b0);
    run_phase(16'd100, 16'd101, 16'd50, 16'd53, 150, 1'b0);
    run_phase(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 50, 1'b0);
    repeat (2) begin
      int l, t;
      l = int'($urandom_range(0, 660)) - 20;
      t = int'($urandom_range(0, 420)) - 20;
      run_phase(16'(l), 16'(l + int'($urandom_range(1, 300)) - 10),
                16'(t), 16'(t + int'($urandom_range(1, 200)) - 10), 200, 1'b0);
    end
    run_phase(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()), 60, 1'b0);
    run_phase(16'd8, 16'd632, 16'd4, 16'd396, 200, 1'b0);
    drain();

    $display("Run covered %0d transactions under %0d clip windows: %0d starts, %0d visible,",
             sent, windows, sb.starts, sb.shown);
    $display("  %0d pixel addresses, %0d completed blits, %0d steps while idle",
             sb.pixels, sb.lasts, sb.idle_steps);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
